>>> hdl/frde_pkg.sv
// frde_pkg: shared types, constants and sequencer states of the fragment record delta encoder
// used by the other files under hdl except frde_ram; depends on nothing else
package frde_pkg;

  // field widths
  localparam int PosW     = 48;
  localparam int LenW     = 16;
  localparam int TileW    = 6;
  localparam int TileCntW = 7;
  localparam int IdxW     = 16;
  localparam int CountW   = 32;
  localparam int ShiftW   = 32;
  localparam int StreamW  = 3;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 16;

  // tile store
  localparam int MaxTiles = 64;

  // constants of the encoding
  localparam logic [PosW-1:0]     EscapeWord      = PosW'(16'hFFFF);
  localparam logic [CountW-1:0]   CountCeiling    = 32'hFFFF_FFFE;
  localparam logic [ShiftW-1:0]   ShiftStep       = 32'd3;
  localparam logic [TileCntW-1:0] TilesInUseReset = 7'd64;
  localparam logic [IdxW-1:0]     IntervalReset   = 16'd1000;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgTilesInUse    = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgIndexInterval = 1'b1;

  // result stream codes
  localparam logic [StreamW-1:0] StrPosition = 3'd0;
  localparam logic [StreamW-1:0] StrLength   = 3'd1;
  localparam logic [StreamW-1:0] StrTile     = 3'd2;
  localparam logic [StreamW-1:0] StrIdxPos   = 3'd3;
  localparam logic [StreamW-1:0] StrIdxShift = 3'd4;
  localparam logic [StreamW-1:0] StrCount    = 3'd5;

  typedef struct packed {
    logic              mode;
    logic [PosW-1:0]   start_position;
    logic [LenW-1:0]   fragment_length;
    logic [TileW-1:0]  tile_number;
  } in_item_t;

  typedef struct packed {
    logic [StreamW-1:0] stream_id;
    logic [PosW-1:0]    word;
    logic               tile_error;
    logic               last;
  } out_item_t;

  // shared adder request and answer
  typedef struct packed {
    logic            sub;
    logic [PosW-1:0] op_a;
    logic [PosW-1:0] op_b;
  } alu_req_t;

  typedef struct packed {
    logic            carry;
    logic [PosW-1:0] sum;
  } alu_res_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DELTA,
    ST_ESC,
    ST_SHIFT,
    ST_COUNT,
    ST_IDX_INC,
    ST_IDX_CMP,
    ST_POS_FIRST,
    ST_POS_HI,
    ST_POS_MID,
    ST_POS_LO,
    ST_LEN,
    ST_TILE,
    ST_IDX_POS,
    ST_IDX_SHIFT,
    ST_DUMP_RD,
    ST_DUMP_EMIT
  } state_t;

endpackage

>>> hdl/frde_ram.sv
// frde_ram: generic single write port, single read port ram with registered read
// stand-alone; no package use
module frde_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, held while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hdl/frde_alu.sv
// frde_alu: shared position-wide adder and subtractor with carry out
// depends on frde_pkg for request and answer types
module frde_alu (
  input  frde_pkg::alu_req_t req,
  output frde_pkg::alu_res_t res
);

  logic [frde_pkg::PosW-1:0] op_b_eff;
  logic [frde_pkg::PosW:0]   total;

  // subtract as a plus inverted b plus one; carry set means no borrow
  assign op_b_eff = req.sub ? ~req.op_b : req.op_b;
  assign total    = {1'b0, req.op_a} + {1'b0, op_b_eff}
                    + {{frde_pkg::PosW{1'b0}}, req.sub};

  assign res.carry = total[frde_pkg::PosW];
  assign res.sum   = total[frde_pkg::PosW-1:0];

endmodule

>>> hdl/fragment_record_delta_encoder_top.sv
// fragment_record_delta_encoder_top: sequencer, state registers and output register
// depends on frde_pkg, frde_alu and frde_ram
//
//   port group   direction   handshake          payload
//   in_          input       in_valid/in_stall   frde_pkg::in_item_t
//   out_         output      out_valid/out_stall frde_pkg::out_item_t
//   cfg_         input       cfg_valid/cfg_ready cfg_index, cfg_data
//
// one item at a time; a fragment passes the shared adder in states delta, esc,
// shift (only with an escaped delta), count, idx_inc and idx_cmp, then emits one
// result word per cycle while the output is not stalled: 3, 5, 6 or 8 words;
// then it returns to idle, which takes the next item.
// a finish item runs a ram read state, then an emit state, for each counted
// tile, then returns to idle.
// reset clears control state, the index counter, shift total and the per-tile
// valid bits, so never-written counts read as zero; no clearing pass is run.
// output stall holds the result register and the sequencer waits behind it.
module fragment_record_delta_encoder_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  frde_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output frde_pkg::out_item_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [frde_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [frde_pkg::CfgDataW-1:0]       cfg_data
);

  localparam logic [frde_pkg::TileCntW-1:0] MaxTilesC = frde_pkg::TileCntW'(frde_pkg::MaxTiles);

  frde_pkg::state_t state_r, state_nxt;

  // configuration
  logic [frde_pkg::TileCntW-1:0] tiles_in_use_r;
  logic [frde_pkg::IdxW-1:0]     interval_r;

  // persistent state
  logic [frde_pkg::PosW-1:0]     prev_pos_r, prev_pos_nxt;
  logic [frde_pkg::ShiftW-1:0]   shift_r, shift_nxt;
  logic [frde_pkg::IdxW-1:0]     idx_r, idx_nxt;
  logic [frde_pkg::MaxTiles-1:0] valid_r, valid_nxt;

  // per-item working registers
  logic [frde_pkg::PosW-1:0]     pos_r;
  logic [frde_pkg::LenW-1:0]     len_r;
  logic [frde_pkg::TileW-1:0]    tile_r;
  logic [frde_pkg::PosW-1:0]     delta_r, delta_nxt;
  logic                          esc_r, esc_nxt;
  logic                          idx_hit_r, idx_hit_nxt;
  logic [frde_pkg::TileCntW-1:0] dump_r, dump_nxt;

  // output register
  logic                 out_valid_r, out_valid_nxt;
  frde_pkg::out_item_t  out_data_r, out_data_nxt;

  logic                          in_accept;
  logic                          slot_free;
  logic                          emit;
  frde_pkg::out_item_t           emit_data;
  logic [frde_pkg::TileCntW-1:0] n_tiles;
  logic                          tile_err;
  logic [frde_pkg::TileCntW-1:0] dump_inc;
  logic                          dump_last;

  frde_pkg::alu_req_t            alu_req;
  frde_pkg::alu_res_t            alu_res;

  logic                          ram_wr_en;
  logic [frde_pkg::CountW-1:0]   ram_wr_data;
  logic                          ram_rd_en;
  logic [frde_pkg::TileW-1:0]    ram_rd_addr;
  logic [frde_pkg::CountW-1:0]   ram_rd_data;
  logic [frde_pkg::CountW-1:0]   cur_count;
  logic [frde_pkg::CountW-1:0]   dump_count;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state_r != frde_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign slot_free = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // active tile count and range check
  assign n_tiles   = (tiles_in_use_r > MaxTilesC) ? MaxTilesC : tiles_in_use_r;
  assign tile_err  = ({1'b0, tile_r} >= n_tiles);
  assign dump_inc  = dump_r + frde_pkg::TileCntW'(1);
  assign dump_last = (dump_inc == n_tiles);

  // count store and its valid bits
  assign cur_count  = valid_r[tile_r] ? ram_rd_data : '0;
  assign dump_count = valid_r[dump_r[frde_pkg::TileW-1:0]] ? ram_rd_data : '0;

  frde_ram #(
    .WIDTH (frde_pkg::CountW),
    .DEPTH (frde_pkg::MaxTiles)
  ) u_count_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (tile_r),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign ram_rd_en   = (in_accept && !in_data.mode) || (state_r == frde_pkg::ST_DUMP_RD);
  assign ram_rd_addr = (state_r == frde_pkg::ST_DUMP_RD) ? dump_r[frde_pkg::TileW-1:0]
                                                         : in_data.tile_number;
  assign ram_wr_en   = (state_r == frde_pkg::ST_COUNT) && !tile_err;
  assign ram_wr_data = (cur_count == frde_pkg::CountCeiling) ? cur_count
                                                             : alu_res.sum[frde_pkg::CountW-1:0];

  // shared adder operand selection
  always_comb begin
    alu_req = '0;
    unique case (state_r)
      frde_pkg::ST_DELTA: begin
        alu_req.sub  = 1'b1;
        alu_req.op_a = pos_r;
        alu_req.op_b = prev_pos_r;
      end
      frde_pkg::ST_ESC: begin
        alu_req.sub  = 1'b1;
        alu_req.op_a = delta_r;
        alu_req.op_b = frde_pkg::EscapeWord;
      end
      frde_pkg::ST_SHIFT: begin
        alu_req.op_a = frde_pkg::PosW'(shift_r);
        alu_req.op_b = frde_pkg::PosW'(frde_pkg::ShiftStep);
      end
      frde_pkg::ST_COUNT: begin
        alu_req.op_a = frde_pkg::PosW'(cur_count);
        alu_req.op_b = frde_pkg::PosW'(1);
      end
      frde_pkg::ST_IDX_INC: begin
        alu_req.op_a = frde_pkg::PosW'(idx_r);
        alu_req.op_b = frde_pkg::PosW'(1);
      end
      frde_pkg::ST_IDX_CMP: begin
        alu_req.sub  = 1'b1;
        alu_req.op_a = frde_pkg::PosW'(idx_r);
        alu_req.op_b = frde_pkg::PosW'(interval_r);
      end
      default: begin
        alu_req = '0;
      end
    endcase
  end

  frde_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      frde_pkg::ST_IDLE: begin
        if (in_accept) begin
          if (!in_data.mode) begin
            state_nxt = frde_pkg::ST_DELTA;
          end else if (n_tiles != '0) begin
            state_nxt = frde_pkg::ST_DUMP_RD;
          end
        end
      end
      frde_pkg::ST_DELTA:   state_nxt = frde_pkg::ST_ESC;
      frde_pkg::ST_ESC:     state_nxt = alu_res.carry ? frde_pkg::ST_SHIFT : frde_pkg::ST_COUNT;
      frde_pkg::ST_SHIFT:   state_nxt = frde_pkg::ST_COUNT;
      frde_pkg::ST_COUNT:   state_nxt = frde_pkg::ST_IDX_INC;
      frde_pkg::ST_IDX_INC: state_nxt = frde_pkg::ST_IDX_CMP;
      frde_pkg::ST_IDX_CMP: state_nxt = frde_pkg::ST_POS_FIRST;
      frde_pkg::ST_POS_FIRST: begin
        if (slot_free) state_nxt = esc_r ? frde_pkg::ST_POS_HI : frde_pkg::ST_LEN;
      end
      frde_pkg::ST_POS_HI:  if (slot_free) state_nxt = frde_pkg::ST_POS_MID;
      frde_pkg::ST_POS_MID: if (slot_free) state_nxt = frde_pkg::ST_POS_LO;
      frde_pkg::ST_POS_LO:  if (slot_free) state_nxt = frde_pkg::ST_LEN;
      frde_pkg::ST_LEN:     if (slot_free) state_nxt = frde_pkg::ST_TILE;
      frde_pkg::ST_TILE: begin
        if (slot_free) state_nxt = idx_hit_r ? frde_pkg::ST_IDX_POS : frde_pkg::ST_IDLE;
      end
      frde_pkg::ST_IDX_POS:   if (slot_free) state_nxt = frde_pkg::ST_IDX_SHIFT;
      frde_pkg::ST_IDX_SHIFT: if (slot_free) state_nxt = frde_pkg::ST_IDLE;
      frde_pkg::ST_DUMP_RD:   state_nxt = frde_pkg::ST_DUMP_EMIT;
      frde_pkg::ST_DUMP_EMIT: begin
        if (slot_free) state_nxt = dump_last ? frde_pkg::ST_IDLE : frde_pkg::ST_DUMP_RD;
      end
      default: state_nxt = frde_pkg::ST_IDLE;
    endcase
  end

  // result word selection
  always_comb begin
    emit      = 1'b0;
    emit_data = '0;
    emit_data.tile_error = tile_err;
    unique case (state_r)
      frde_pkg::ST_POS_FIRST: begin
        emit                = 1'b1;
        emit_data.stream_id = frde_pkg::StrPosition;
        emit_data.word      = esc_r ? frde_pkg::EscapeWord
                                    : frde_pkg::PosW'(delta_r[15:0]);
      end
      frde_pkg::ST_POS_HI: begin
        emit                = 1'b1;
        emit_data.stream_id = frde_pkg::StrPosition;
        emit_data.word      = frde_pkg::PosW'(delta_r[47:32]);
      end
      frde_pkg::ST_POS_MID: begin
        emit                = 1'b1;
        emit_data.stream_id = frde_pkg::StrPosition;
        emit_data.word      = frde_pkg::PosW'(delta_r[31:16]);
      end
      frde_pkg::ST_POS_LO: begin
        emit                = 1'b1;
        emit_data.stream_id = frde_pkg::StrPosition;
        emit_data.word      = frde_pkg::PosW'(delta_r[15:0]);
      end
      frde_pkg::ST_LEN: begin
        emit                = 1'b1;
        emit_data.stream_id = frde_pkg::StrLength;
        emit_data.word      = frde_pkg::PosW'(len_r);
      end
      frde_pkg::ST_TILE: begin
        emit                = 1'b1;
        emit_data.stream_id = frde_pkg::StrTile;
        emit_data.word      = frde_pkg::PosW'(tile_r);
        emit_data.last      = !idx_hit_r;
      end
      frde_pkg::ST_IDX_POS: begin
        emit                = 1'b1;
        emit_data.stream_id = frde_pkg::StrIdxPos;
        emit_data.word      = prev_pos_r;
      end
      frde_pkg::ST_IDX_SHIFT: begin
        emit                = 1'b1;
        emit_data.stream_id = frde_pkg::StrIdxShift;
        emit_data.word      = frde_pkg::PosW'(shift_r);
        emit_data.last      = 1'b1;
      end
      frde_pkg::ST_DUMP_EMIT: begin
        emit                 = 1'b1;
        emit_data.stream_id  = frde_pkg::StrCount;
        emit_data.word       = frde_pkg::PosW'(dump_count);
        emit_data.tile_error = 1'b0;
        emit_data.last       = dump_last;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // working and persistent state updates
  always_comb begin
    prev_pos_nxt = prev_pos_r;
    shift_nxt    = shift_r;
    idx_nxt      = idx_r;
    valid_nxt    = valid_r;
    delta_nxt    = delta_r;
    esc_nxt      = esc_r;
    idx_hit_nxt  = idx_hit_r;
    dump_nxt     = dump_r;
    case (state_r)
      frde_pkg::ST_IDLE: begin
        dump_nxt = '0;
      end
      frde_pkg::ST_DELTA: begin
        delta_nxt    = alu_res.sum;
        prev_pos_nxt = pos_r;
      end
      frde_pkg::ST_ESC: begin
        esc_nxt = alu_res.carry;
      end
      frde_pkg::ST_SHIFT: begin
        shift_nxt = alu_res.sum[frde_pkg::ShiftW-1:0];
      end
      frde_pkg::ST_COUNT: begin
        if (!tile_err) valid_nxt[tile_r] = 1'b1;
      end
      frde_pkg::ST_IDX_INC: begin
        idx_nxt = alu_res.sum[frde_pkg::IdxW-1:0];
      end
      frde_pkg::ST_IDX_CMP: begin
        idx_hit_nxt = alu_res.carry;
        if (alu_res.carry) idx_nxt = '0;
      end
      frde_pkg::ST_DUMP_EMIT: begin
        if (slot_free) dump_nxt = dump_inc;
      end
      default: begin
        dump_nxt = dump_r;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (emit && slot_free) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = emit_data;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= frde_pkg::ST_IDLE;
      out_valid_r    <= 1'b0;
      tiles_in_use_r <= frde_pkg::TilesInUseReset;
      interval_r     <= frde_pkg::IntervalReset;
      prev_pos_r     <= '0;
      shift_r        <= '0;
      idx_r          <= '0;
      valid_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      prev_pos_r  <= prev_pos_nxt;
      shift_r     <= shift_nxt;
      idx_r       <= idx_nxt;
      valid_r     <= valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          frde_pkg::CfgTilesInUse:    tiles_in_use_r <= cfg_data[frde_pkg::TileCntW-1:0];
          frde_pkg::CfgIndexInterval: interval_r     <= cfg_data;
          default:                    interval_r     <= interval_r;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      pos_r  <= in_data.start_position;
      len_r  <= in_data.fragment_length;
      tile_r <= in_data.tile_number;
    end
    delta_r    <= delta_nxt;
    esc_r      <= esc_nxt;
    idx_hit_r  <= idx_hit_nxt;
    dump_r     <= dump_nxt;
    out_data_r <= out_data_nxt;
  end

  // a fragment always keeps the block busy on the next cycle
  a_frag_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && !in_data.mode |=> in_stall)
    else $error("fragment accepted but block idle next cycle");

  // short streams carry 16-bit words only
  a_word_width: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.stream_id == frde_pkg::StrPosition ||
                  out_data.stream_id == frde_pkg::StrLength ||
                  out_data.stream_id == frde_pkg::StrTile)
    |-> out_data.word[frde_pkg::PosW-1:16] == '0)
    else $error("16-bit stream word has high bits set");

  // tile count results never flag an error
  a_count_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.stream_id == frde_pkg::StrCount |-> !out_data.tile_error)
    else $error("tile count result carries tile error");

  // the store is never written for an out-of-range tile
  a_no_bad_write: assert property (@(posedge clk) disable iff (!rst_n)
    ram_wr_en |-> ({1'b0, tile_r} < n_tiles))
    else $error("count write for uncounted tile");

  // index shift record always follows the index position record
  a_idx_pair: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == frde_pkg::ST_IDX_POS && slot_free |=> state_r == frde_pkg::ST_IDX_SHIFT)
    else $error("index position without index shift");

endmodule

>>> sim/fragment_record_delta_encoder_top_tb.sv
`timescale 1ns / 1ps
// fragment_record_delta_encoder_top_tb: self-checking bench for the fragment record delta encoder
// drives directed and random records and checks every word against an encoder kept in the bench
// depends on frde_pkg and fragment_record_delta_encoder_top
module fragment_record_delta_encoder_top_tb;

  localparam int CycleLimit   = 4000000;
  localparam int LongHold     = 400;
  localparam int SettleCycles = 40;
  localparam int RandomPhases = 6;
  localparam int PhaseRecords = 50;

  logic                          clk       = 1'b0;
  logic                          rst_n     = 1'b0;
  logic                          in_valid  = 1'b0;
  logic                          in_stall;
  frde_pkg::in_item_t            in_data   = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  frde_pkg::out_item_t           out_data;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [frde_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [frde_pkg::CfgDataW-1:0] cfg_data  = '0;

  fragment_record_delta_encoder_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // encoder state and register copies held by the bench
  logic [frde_pkg::TileCntW-1:0] tiles_reg    = frde_pkg::TilesInUseReset;
  logic [frde_pkg::IdxW-1:0]     interval_reg = frde_pkg::IntervalReset;
  logic [frde_pkg::PosW-1:0]     prev_pos     = '0;
  logic [frde_pkg::ShiftW-1:0]   shift_sum    = '0;
  logic [frde_pkg::IdxW-1:0]     frag_count   = '0;
  logic [frde_pkg::CountW-1:0]   tile_tally [frde_pkg::MaxTiles];

  frde_pkg::in_item_t        records_to_send [$];
  frde_pkg::out_item_t       expected_words [$];
  logic [frde_pkg::PosW-1:0] gen_pos = '0;

  int          send_pct       = 0;
  int          recv_pct       = 0;
  int          send_gap       = 0;
  int          stall_left     = 0;
  int          hold_left      = 0;
  int          hold_requests  = 0;
  int          holds_done     = 0;
  int          mismatch_count = 0;
  int unsigned cycle_count    = 0;

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // gap length: mostly none, some short, a few long
  function automatic int idle_length(input int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) < 8) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic void push_word(input logic [frde_pkg::StreamW-1:0] sid,
                                    input logic [frde_pkg::PosW-1:0] w,
                                    input logic err);
    frde_pkg::out_item_t o;
    o.stream_id  = sid;
    o.word       = w;
    o.tile_error = err;
    o.last       = 1'b0;
    expected_words = {expected_words, o};
  endfunction

  // append one record to the driver's queue
  function automatic void queue_record(input frde_pkg::in_item_t rec);
    records_to_send = {records_to_send, rec};
  endfunction

  // words the encoder should emit for one record, with state update
  function automatic void encode_expected(input frde_pkg::in_item_t rec);
    int unsigned               active;
    int                        first;
    logic [frde_pkg::PosW-1:0] delta;
    logic                      err;
    active = (tiles_reg > frde_pkg::MaxTiles) ? frde_pkg::MaxTiles : tiles_reg;
    first  = expected_words.size();
    if (rec.mode) begin
      // finish: dump counts untouched
      for (int t = 0; t < active; t++)
        push_word(frde_pkg::StrCount, frde_pkg::PosW'(tile_tally[t]), 1'b0);
    end else begin
      delta    = rec.start_position - prev_pos;
      err      = (rec.tile_number >= active);
      prev_pos = rec.start_position;
      if (delta < frde_pkg::EscapeWord) begin
        push_word(frde_pkg::StrPosition, delta, err);
      end else begin
        // escaped delta: marker then three 16-bit pieces
        push_word(frde_pkg::StrPosition, frde_pkg::EscapeWord, err);
        push_word(frde_pkg::StrPosition, frde_pkg::PosW'(delta[47:32]), err);
        push_word(frde_pkg::StrPosition, frde_pkg::PosW'(delta[31:16]), err);
        push_word(frde_pkg::StrPosition, frde_pkg::PosW'(delta[15:0]), err);
        shift_sum = shift_sum + frde_pkg::ShiftStep;
      end
      push_word(frde_pkg::StrLength, frde_pkg::PosW'(rec.fragment_length), err);
      push_word(frde_pkg::StrTile, frde_pkg::PosW'(rec.tile_number), err);
      if (!err && tile_tally[rec.tile_number] < frde_pkg::CountCeiling)
        tile_tally[rec.tile_number] = tile_tally[rec.tile_number] + 1'b1;
      frag_count = frag_count + 1'b1;
      if (frag_count >= interval_reg) begin
        push_word(frde_pkg::StrIdxPos, prev_pos, err);
        push_word(frde_pkg::StrIdxShift, frde_pkg::PosW'(shift_sum), err);
        frag_count = '0;
      end
    end
    if (expected_words.size() > first)
      expected_words[expected_words.size() - 1].last = 1'b1;
  endfunction

  function automatic void check_field(input string field,
                                      input logic [frde_pkg::PosW-1:0] want,
                                      input logic [frde_pkg::PosW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
      mismatch_count++;
    end
  endfunction

  function automatic frde_pkg::in_item_t fragment(input logic [frde_pkg::PosW-1:0] pos,
                                                  input logic [frde_pkg::LenW-1:0] len,
                                                  input logic [frde_pkg::TileW-1:0] tile);
    frde_pkg::in_item_t rec;
    rec.mode            = 1'b0;
    rec.start_position  = pos;
    rec.fragment_length = len;
    rec.tile_number     = tile;
    return rec;
  endfunction

  // finish record; the other fields carry junk that must be ignored
  function automatic frde_pkg::in_item_t finish_record(input logic fill);
    frde_pkg::in_item_t rec;
    rec      = fill ? '1 : '0;
    rec.mode = 1'b1;
    return rec;
  endfunction

  // mostly nearby positions, some around the escape boundary, some far jumps
  function automatic frde_pkg::in_item_t random_record(input int unsigned tile_span);
    frde_pkg::in_item_t rec;
    int unsigned        pick;
    rec.mode            = 1'b0;
    rec.start_position  = frde_pkg::PosW'({$urandom(), $urandom()});
    rec.fragment_length = frde_pkg::LenW'($urandom());
    rec.tile_number     = frde_pkg::TileW'($urandom());
    if ($urandom_range(99) < 6) begin
      rec.mode = 1'b1;
      return rec;
    end
    pick = $urandom_range(99);
    if (pick < 60)
      rec.start_position = gen_pos + frde_pkg::PosW'($urandom_range(2000));
    else if (pick < 72)
      rec.start_position = gen_pos + frde_pkg::PosW'($urandom_range(65536, 65533));
    else if (pick < 85)
      rec.start_position = gen_pos + frde_pkg::PosW'({$urandom(), $urandom()});
    if (tile_span > 0 && $urandom_range(99) < 85)
      rec.tile_number = frde_pkg::TileW'($urandom_range(tile_span - 1));
    gen_pos = rec.start_position;
    return rec;
  endfunction

  // input driver: one record per transfer, random gaps between them
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) encode_expected(in_data);
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (records_to_send.size() > 0) begin
        in_data  <= records_to_send.pop_front();
        in_valid <= 1'b1;
        send_gap = idle_length(send_pct);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side back-pressure: random stalls plus the occasional long hold
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0 || holds_done < hold_requests) begin
      if (hold_left == 0) begin
        holds_done++;
        hold_left = LongHold;
      end
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      stall_left = idle_length(recv_pct);
      out_stall <= 1'b0;
    end
  end

  // result monitor: compare each transfer with the oldest expected word
  always @(posedge clk) begin : result_check
    frde_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected result, expected none actual stream %0d word %0h",
                 $time, out_data.stream_id, out_data.word);
        mismatch_count++;
      end else begin
        want = expected_words.pop_front();
        check_field("stream_id", frde_pkg::PosW'(want.stream_id),
                    frde_pkg::PosW'(out_data.stream_id));
        check_field("word", want.word, out_data.word);
        check_field("tile_error", frde_pkg::PosW'(want.tile_error),
                    frde_pkg::PosW'(out_data.tile_error));
        check_field("last", frde_pkg::PosW'(want.last), frde_pkg::PosW'(out_data.last));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout with %0d words outstanding", $time, expected_words.size());
      $display("** fragment_record_delta_encoder_top: FAILED **");
      $finish;
    end
  end

  task automatic wait_drained();
    while (records_to_send.size() != 0 || in_valid || expected_words.size() != 0)
      @(posedge clk);
    // a finish with no counted tile leaves nothing to wait on
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_register(input logic [frde_pkg::CfgIdxW-1:0] idx,
                                input logic [frde_pkg::CfgDataW-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == frde_pkg::CfgTilesInUse) tiles_reg = value[frde_pkg::TileCntW-1:0];
    else interval_reg = value[frde_pkg::IdxW-1:0];
  endtask

  // idle the block, reprogram both registers, set the idling mix
  task automatic start_phase(input logic [frde_pkg::CfgDataW-1:0] tiles,
                             input logic [frde_pkg::CfgDataW-1:0] gap,
                             input int s_pct, input int r_pct);
    wait_drained();
    write_register(frde_pkg::CfgTilesInUse, tiles);
    write_register(frde_pkg::CfgIndexInterval, gap);
    @(negedge clk);
    send_pct = s_pct;
    recv_pct = r_pct;
  endtask

  initial begin : stimulus
    logic [frde_pkg::CfgDataW-1:0] tiles_pick;
    logic [frde_pkg::CfgDataW-1:0] interval_pick;
    for (int t = 0; t < frde_pkg::MaxTiles; t++) tile_tally[t] = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // full tile range, index record after every fragment; delta edges and field extremes
    start_phase(16'd64, 16'd1, 0, 0);
    queue_record(fragment(48'd0, 16'd0, 6'd0));
    queue_record(fragment(48'd65534, 16'hFFFF, 6'd63));
    queue_record(fragment(48'd131069, 16'd1, 6'd1));
    queue_record(fragment(48'hFFFF_FFFF_FFFF, 16'hAAAA, 6'd62));
    queue_record(fragment(48'd0, 16'h5555, 6'd5));
    queue_record(fragment(48'd0, 16'd7, 6'd0));
    queue_record(finish_record(1'b1));

    // single tile, zero interval acting as one; tiles out of range
    start_phase(16'd1, 16'd0, 20, 20);
    queue_record(fragment(48'd10, 16'd3, 6'd0));
    queue_record(fragment(48'd20, 16'd4, 6'd1));
    queue_record(fragment(48'd30, 16'd5, 6'd63));
    queue_record(finish_record(1'b0));

    // no tile counted: every fragment flagged, finish gives nothing
    start_phase(16'd0, 16'hFFFF, 0, 0);
    queue_record(fragment(48'd40, 16'd6, 6'd0));
    queue_record(finish_record(1'b1));

    // tile register above the store size acts as the full store
    start_phase(16'd127, 16'd2, 0, 20);
    queue_record(fragment(48'd50, 16'd8, 6'd63));
    queue_record(fragment(48'd60, 16'd9, 6'd2));
    queue_record(finish_record(1'b0));
    gen_pos = 48'd60;

    // random phases with varied settings and idling
    for (int p = 0; p < RandomPhases; p++) begin
      case (p)
        0: begin
          tiles_pick    = 16'd64;
          interval_pick = 16'd3;
        end
        1: begin
          tiles_pick    = 16'd1;
          interval_pick = 16'd1;
        end
        default: begin
          tiles_pick    = ($urandom_range(3) == 0) ? 16'd64
                                                   : frde_pkg::CfgDataW'($urandom_range(64, 1));
          interval_pick = ($urandom_range(3) == 0) ? 16'hFFFF
                                                   : frde_pkg::CfgDataW'($urandom_range(10, 1));
        end
      endcase
      start_phase(tiles_pick, interval_pick, (p % 3 == 2) ? 0 : 25, (p % 3 == 1) ? 0 : 30);
      // long receiver hold while records keep coming
      if (p == 0 || p == 4) hold_requests++;
      for (int k = 0; k < PhaseRecords; k++)
        queue_record(random_record(tiles_pick));
    end

    wait_drained();
    @(negedge clk);
    if (mismatch_count == 0) begin
      $display("** fragment_record_delta_encoder_top: PASSED **");
    end else begin
      $display("** fragment_record_delta_encoder_top: FAILED **");
    end
    $finish;
  end

endmodule
